// ----- src/ttb_pkg.sv -----
// ----------------------------------------------------------------------------
// ttb_pkg: shared constants for the triangle tangent basis unit
// Output format and fraction width used by the divider and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

    localparam int OUT_W     = 32;   // Q16.16 result width
    localparam int FRAC_BITS = 16;   // fraction bits of every result

    typedef logic signed [OUT_W-1:0] t_res;

endpackage

`default_nettype wire

// ----- src/ttb_ifs.sv -----
// ----------------------------------------------------------------------------
// ttb_ifs: valid/ready channel interfaces
// Vertex input channel and tangent/bitangent result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ttb_vtx_if #(
    parameter int POS_WIDTH = 32,
    parameter int UV_WIDTH  = 24
) ();
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] pos_x;
    logic signed [POS_WIDTH-1:0] pos_y;
    logic signed [POS_WIDTH-1:0] pos_z;
    logic signed [UV_WIDTH-1:0]  tex_u;
    logic signed [UV_WIDTH-1:0]  tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_res_if ();
    logic          valid;
    logic          ready;
    ttb_pkg::t_res tangent_x;
    ttb_pkg::t_res tangent_y;
    ttb_pkg::t_res tangent_z;
    ttb_pkg::t_res bitangent_x;
    ttb_pkg::t_res bitangent_y;
    ttb_pkg::t_res bitangent_z;
    logic          degenerate;
    logic          last_copy;

    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, last_copy, input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, last_copy, output ready);
endinterface

`default_nettype wire

// ----- src/ttb_div.sv -----
// ----------------------------------------------------------------------------
// ttb_div: bit-serial restoring divider
// (num * 2^16) / den, truncated toward zero, saturated to signed Q16.16.
// One quotient bit per cycle; den must be nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_div #(
    parameter int ACC_W = 59
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [ACC_W-1:0] i_num,
    input  wire logic signed [ACC_W-1:0] i_den,
    output      logic                    o_done,
    output      ttb_pkg::t_res           o_quot
);

    localparam int NW  = ACC_W + ttb_pkg::FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);
    localparam int QW  = ttb_pkg::OUT_W + 1;

    logic [NW-1:0]    r_n;
    logic [ACC_W-1:0] r_d;
    logic [ACC_W:0]   r_r;
    logic [QW-1:0]    r_q;
    logic             r_ovf;
    logic             r_neg;
    logic [CNW-1:0]   r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [ACC_W-1:0] num_mag;
    logic [ACC_W-1:0] den_mag;
    logic [ACC_W:0]   rs;
    logic             ge;

    assign num_mag = i_num[ACC_W-1] ? ACC_W'(-i_num) : ACC_W'(i_num);
    assign den_mag = i_den[ACC_W-1] ? ACC_W'(-i_den) : ACC_W'(i_den);
    assign rs      = {r_r[ACC_W-1:0], r_n[NW-1]};
    assign ge      = rs >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= {num_mag, {ttb_pkg::FRAC_BITS{1'b0}}};
            r_d   <= den_mag;
            r_r   <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_neg <= i_num[ACC_W-1] ^ i_den[ACC_W-1];
        end else if (r_busy) begin
            r_r   <= ge ? (rs - {1'b0, r_d}) : rs;
            r_ovf <= r_ovf | r_q[QW-1];   // quotient bits above bit 32 only flag overflow
            r_q   <= {r_q[QW-2:0], ge};
            r_n   <= {r_n[NW-2:0], 1'b0};
        end
    end

    logic big;
    assign big = r_ovf | r_q[QW-1];

    always_comb begin
        if (r_neg) begin
            if (big || (r_q > QW'({1'b1, {(ttb_pkg::OUT_W-1){1'b0}}}))) begin
                o_quot = {1'b1, {(ttb_pkg::OUT_W-1){1'b0}}};
            end else begin
                o_quot = ttb_pkg::OUT_W'(-r_q[ttb_pkg::OUT_W-1:0]);
            end
        end else begin
            if (big || r_q[ttb_pkg::OUT_W-1]) begin
                o_quot = {1'b0, {(ttb_pkg::OUT_W-1){1'b1}}};
            end else begin
                o_quot = r_q[ttb_pkg::OUT_W-1:0];
            end
        end
    end

    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with empty count");
`endif

endmodule

`default_nettype wire

// ----- src/triangle_tangent_basis_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_tangent_basis_unit: per-triangle tangent and bitangent
// Holds two vertices, then on the third forms edge deltas, the UV determinant
// and six quotients through one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
//  channel | dir | word
//  i_vtx   | in  | pos_x/y/z (Q16.16), tex_u/v (Q8.16), one vertex
//  o_res   | out | tangent/bitangent x/y/z (Q16.16), degenerate, last_copy
//
//  First and second vertex of a triangle: accepted and stored, no word out.
//  Third vertex: two products for the determinant, then per component two
//  products plus a divider run over NW = ACC_W+16 bits (75 by default);
//  a zero determinant skips the divider entirely.
//  Three copies of the result word then go out, one per accepted o_res handshake;
//  i_vtx.ready is low from the third vertex until the last word is taken.
//  Reset is synchronous, active low, and clears the vertex count and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_basis_unit #(
    parameter int POS_WIDTH = 32,
    parameter int UV_WIDTH  = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ttb_vtx_if.sink    i_vtx,
    ttb_res_if.source  o_res
);

    localparam int PD_W  = POS_WIDTH + 1;
    localparam int UD_W  = UV_WIDTH + 1;
    localparam int A_W   = ((POS_WIDTH > UV_WIDTH) ? POS_WIDTH : UV_WIDTH) + 1;
    localparam int P_W   = A_W + UD_W;
    localparam int ACC_W = P_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] r_corner;
    logic [2:0] r_step;     // 0: determinant, 1..3 tangent, 4..6 bitangent
    logic       r_ph;
    logic       r_start;
    logic [1:0] r_copy;
    logic       r_degen;

    logic signed [POS_WIDTH-1:0] r_p0 [3];
    logic signed [POS_WIDTH-1:0] r_p1 [3];
    logic signed [UV_WIDTH-1:0]  r_t0 [2];
    logic signed [UV_WIDTH-1:0]  r_t1 [2];
    logic signed [PD_W-1:0]      r_dp1 [3];
    logic signed [PD_W-1:0]      r_dp2 [3];
    logic signed [UD_W-1:0]      r_du1, r_dv1, r_du2, r_dv2;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [ACC_W-1:0]     r_det;
    ttb_pkg::t_res               r_res [6];

    logic                    accept;
    logic signed [POS_WIDTH-1:0] in_p [3];
    logic [1:0]              k;
    logic signed [A_W-1:0]   op_a;
    logic signed [UD_W-1:0]  op_b;
    logic signed [P_W-1:0]   prod;
    logic signed [ACC_W-1:0] n_acc;
    logic                    div_done;
    ttb_pkg::t_res           div_q;

    assign accept = i_vtx.valid && i_vtx.ready;
    assign in_p[0] = i_vtx.pos_x;
    assign in_p[1] = i_vtx.pos_y;
    assign in_p[2] = i_vtx.pos_z;

    assign k = (r_step >= 3'd4) ? 2'(r_step - 3'd4) : 2'(r_step - 3'd1);

    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_step == 3'd0) begin
            op_a = r_ph ? A_W'(r_dv1) : A_W'(r_du1);
            op_b = r_ph ? r_du2 : r_dv2;
        end else if (r_step <= 3'd3) begin
            op_a = r_ph ? A_W'(r_dp2[k]) : A_W'(r_dp1[k]);
            op_b = r_ph ? r_dv1 : r_dv2;
        end else begin
            op_a = r_ph ? A_W'(r_dp1[k]) : A_W'(r_dp2[k]);
            op_b = r_ph ? r_du2 : r_du1;
        end
    end

    assign prod  = P_W'(op_a) * P_W'(op_b);
    assign n_acc = r_acc - ACC_W'(prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_corner <= '0;
            r_step   <= '0;
            r_ph     <= 1'b0;
            r_start  <= 1'b0;
            r_copy   <= '0;
        end else begin
            // divider kicks off after the second product of a component
            r_start <= (r_state == ST_MUL) && r_ph && (r_step != 3'd0);
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (r_corner == 2'd2) begin
                            r_corner <= '0;
                            r_state  <= ST_MUL;
                            r_step   <= '0;
                            r_ph     <= 1'b0;
                        end else begin
                            r_corner <= r_corner + 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_step == 3'd0) begin
                            if (n_acc == '0) begin
                                r_state <= ST_EMIT;
                                r_copy  <= '0;
                            end else begin
                                r_step <= 3'd1;
                            end
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (r_step == 3'd6) begin
                            r_state <= ST_EMIT;
                            r_copy  <= '0;
                        end else begin
                            r_step  <= r_step + 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_EMIT: begin
                    if (o_res.ready) begin
                        if (r_copy == 2'd2) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_copy <= r_copy + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && r_corner == 2'd0) begin
            for (int i = 0; i < 3; i++) r_p0[i] <= in_p[i];
            r_t0[0] <= i_vtx.tex_u;
            r_t0[1] <= i_vtx.tex_v;
        end
        if (accept && r_corner == 2'd1) begin
            for (int i = 0; i < 3; i++) r_p1[i] <= in_p[i];
            r_t1[0] <= i_vtx.tex_u;
            r_t1[1] <= i_vtx.tex_v;
        end
        if (accept && r_corner == 2'd2) begin
            for (int i = 0; i < 3; i++) begin
                r_dp1[i] <= PD_W'(r_p1[i]) - PD_W'(r_p0[i]);
                r_dp2[i] <= PD_W'(in_p[i]) - PD_W'(r_p0[i]);
            end
            r_du1 <= UD_W'(r_t1[0]) - UD_W'(r_t0[0]);
            r_dv1 <= UD_W'(r_t1[1]) - UD_W'(r_t0[1]);
            r_du2 <= UD_W'(i_vtx.tex_u) - UD_W'(r_t0[0]);
            r_dv2 <= UD_W'(i_vtx.tex_v) - UD_W'(r_t0[1]);
        end
        if (r_state == ST_MUL) begin
            if (!r_ph) begin
                r_acc <= ACC_W'(prod);
            end else begin
                r_acc <= n_acc;
                if (r_step == 3'd0) begin
                    r_det   <= n_acc;
                    r_degen <= (n_acc == '0);
                    if (n_acc == '0) begin
                        for (int i = 0; i < 6; i++) r_res[i] <= '0;
                    end
                end
            end
        end
        if (r_state == ST_DIV && div_done) begin
            r_res[3'(r_step - 3'd1)] <= div_q;
        end
    end

    ttb_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   (r_acc),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign i_vtx.ready       = (r_state == ST_IDLE);
    assign o_res.valid       = (r_state == ST_EMIT);
    assign o_res.tangent_x   = r_res[0];
    assign o_res.tangent_y   = r_res[1];
    assign o_res.tangent_z   = r_res[2];
    assign o_res.bitangent_x = r_res[3];
    assign o_res.bitangent_y = r_res[4];
    assign o_res.bitangent_z = r_res[5];
    assign o_res.degenerate  = r_degen;
    assign o_res.last_copy   = (r_copy == 2'd2);

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_vtx.ready && o_res.valid))
        else $error("input ready while results pending");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.degenerate) |-> (r_res[0] == '0 && r_res[5] == '0))
        else $error("degenerate word with nonzero vector");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide phase");
    a_last_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && o_res.last_copy) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last word");
`endif

endmodule

`default_nettype wire
